// ----- rtl/pipct_pkg.sv -----
package pipct_pkg;

  // entries of the queue between front and back, a power of two
  localparam int unsigned QUEUE_DEPTH = 4;

  // edge classification made by the front for one vertex
  typedef struct packed {
    logic last;         // vertex closes the polygon
    logic edge_cross;   // edge from this vertex to the previous one straddles the point's y
    logic close_cross;  // closing edge from the first vertex to this one straddles
  } item_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- rtl/pipct_front.sv -----
module pipct_front #(
  parameter int unsigned INT_BITS  = 16,
  parameter int unsigned FRAC_BITS = 8,
  localparam int unsigned IN_W   = INT_BITS + FRAC_BITS,
  localparam int unsigned VW     = INT_BITS + 1,
  localparam int unsigned DATA_W = 2 * IN_W + 6 * VW
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [IN_W-1:0]   query_x_i,
  input  logic signed [IN_W-1:0]   query_y_i,
  input  logic signed [IN_W-1:0]   corner_x_i,
  input  logic signed [IN_W-1:0]   corner_y_i,
  input  logic                     final_corner_i,
  input  pipct_pkg::q_stat_t       q_stat_i,
  output logic                     push_o,
  output pipct_pkg::item_ctl_t     ctl_o,
  output logic [DATA_W-1:0]        data_o
);
  import pipct_pkg::*;

  localparam int unsigned SW = VW + FRAC_BITS;

  logic                   accept;
  logic signed [IN_W-1:0] raw [2];
  logic signed [VW-1:0]   rnd [2];
  logic signed [VW-1:0]   cx, cy;
  logic signed [VW-1:0]   fx_sel, fy_sel;
  logic signed [SW-1:0]   cur_ys, prev_ys, first_ys;
  logic                   cur_above, prev_above, first_above;

  logic signed [VW-1:0]   first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic                   have_first_q;

  assign accept     = in_valid_i && !q_stat_i.full;
  assign in_stall_o = q_stat_i.full;
  assign push_o     = accept;

  assign raw[0] = corner_x_i;
  assign raw[1] = corner_y_i;

  // round to nearest integer, ties to even
  for (genvar g = 0; g < 2; g++) begin : g_round
    if (FRAC_BITS == 0) begin : g_int
      assign rnd[g] = VW'(raw[g]);
    end else begin : g_frac
      localparam logic [FRAC_BITS-1:0] HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);
      logic signed [INT_BITS-1:0] fl;
      logic [FRAC_BITS-1:0]       frac;
      logic                       up;
      assign fl   = raw[g][IN_W-1:FRAC_BITS];
      assign frac = raw[g][FRAC_BITS-1:0];
      assign up   = (frac > HALF) || ((frac == HALF) && fl[0]);
      assign rnd[g] = VW'(fl) + VW'(up);
    end
  end

  assign cx = rnd[0];
  assign cy = rnd[1];

  // before the first vertex is stored the closing edge degenerates to a point
  assign fx_sel = have_first_q ? first_x_q : cx;
  assign fy_sel = have_first_q ? first_y_q : cy;

  assign cur_ys   = SW'(cy) <<< FRAC_BITS;
  assign prev_ys  = SW'(prev_y_q) <<< FRAC_BITS;
  assign first_ys = SW'(fy_sel) <<< FRAC_BITS;

  assign cur_above   = cur_ys > query_y_i;
  assign prev_above  = prev_ys > query_y_i;
  assign first_above = first_ys > query_y_i;

  // the closing edge only counts on the vertex that ends the polygon
  assign ctl_o.last        = final_corner_i;
  assign ctl_o.edge_cross  = have_first_q && (cur_above != prev_above);
  assign ctl_o.close_cross = final_corner_i && (first_above != cur_above);

  assign data_o = {query_x_i, query_y_i, cx, cy, prev_x_q, prev_y_q, fx_sel, fy_sel};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_x_q    <= '0;
      first_y_q    <= '0;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      have_first_q <= 1'b0;
    end else if (accept) begin
      if (final_corner_i) begin
        first_x_q    <= '0;
        first_y_q    <= '0;
        prev_x_q     <= '0;
        prev_y_q     <= '0;
        have_first_q <= 1'b0;
      end else begin
        if (!have_first_q) begin
          first_x_q <= cx;
          first_y_q <= cy;
        end
        prev_x_q     <= cx;
        prev_y_q     <= cy;
        have_first_q <= 1'b1;
      end
    end
  end

endmodule

// ----- rtl/pipct_queue.sv -----
module pipct_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic               pop_i,
  input  logic [WIDTH-1:0]   wdata_i,
  output logic [WIDTH-1:0]   rdata_o,
  output pipct_pkg::q_stat_t stat_o
);
  import pipct_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign rdata_o      = slot_q[rd_ptr_q];
  assign stat_o.full  = count_q == CNT_W'(QUEUE_DEPTH);
  assign stat_o.empty = count_q == '0;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/pipct_back.sv -----
module pipct_back #(
  parameter int unsigned INT_BITS  = 16,
  parameter int unsigned FRAC_BITS = 8,
  localparam int unsigned IN_W   = INT_BITS + FRAC_BITS,
  localparam int unsigned VW     = INT_BITS + 1,
  localparam int unsigned DATA_W = 2 * IN_W + 6 * VW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pipct_pkg::q_stat_t   q_stat_i,
  output logic                 pop_o,
  input  pipct_pkg::item_ctl_t ctl_i,
  input  logic [DATA_W-1:0]    data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 inside_res_o
);
  import pipct_pkg::*;

  localparam int unsigned SW = VW + FRAC_BITS;
  localparam int unsigned AW = IN_W + 2;
  localparam int unsigned DW = VW + 1;
  localparam int unsigned PW = AW + DW;

  logic                   adv;
  logic signed [IN_W-1:0] px, py;
  logic signed [VW-1:0]   cx, cy, prx, pry, fx, fy;
  logic signed [VW-1:0]   xi [2], yi [2], xj [2], yj [2];
  logic signed [AW-1:0]   a_d [2], b_d [2];
  logic signed [DW-1:0]   dx_d [2], dy_d [2];
  logic [1:0]             toggle;
  logic                   par_nxt;

  logic                   s1_v_q, s2_v_q;
  item_ctl_t              s1_ctl_q, s2_ctl_q;
  logic signed [AW-1:0]   s1_a_q [2], s1_b_q [2];
  logic signed [DW-1:0]   s1_dx_q [2], s1_dy_q [2];
  logic signed [PW-1:0]   s2_p1_q [2], s2_p2_q [2];
  logic [1:0]             s2_dir_q;
  logic                   parity_q, out_valid_q, inside_q;

  // the whole back end moves unless a result sits stalled at the output
  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = adv && !q_stat_i.empty;

  assign {px, py, cx, cy, prx, pry, fx, fy} = data_i;

  // edge 0: this vertex to the previous one; edge 1: first vertex to this one
  assign xi[0] = cx;
  assign yi[0] = cy;
  assign xj[0] = prx;
  assign yj[0] = pry;
  assign xi[1] = fx;
  assign yi[1] = fy;
  assign xj[1] = cx;
  assign yj[1] = cy;

  for (genvar e = 0; e < 2; e++) begin : g_edge
    logic signed [SW-1:0] xs, ys;
    assign xs      = SW'(xi[e]) <<< FRAC_BITS;
    assign ys      = SW'(yi[e]) <<< FRAC_BITS;
    assign a_d[e]  = AW'(px) - AW'(xs);
    assign b_d[e]  = AW'(py) - AW'(ys);
    assign dx_d[e] = DW'(xj[e]) - DW'(xi[e]);
    assign dy_d[e] = DW'(yj[e]) - DW'(yi[e]);
    // dy is nonzero whenever the edge straddles, so its sign picks the direction
    assign toggle[e] = (e == 0 ? s2_ctl_q.edge_cross : s2_ctl_q.close_cross) &&
                       (s2_dir_q[e] ? (s2_p1_q[e] < s2_p2_q[e])
                                    : (s2_p2_q[e] < s2_p1_q[e]));
  end

  assign par_nxt = parity_q ^ toggle[0] ^ toggle[1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ctl_q <= ctl_i;
      s2_ctl_q <= s1_ctl_q;
      for (int e = 0; e < 2; e++) begin
        s1_a_q[e]   <= a_d[e];
        s1_b_q[e]   <= b_d[e];
        s1_dx_q[e]  <= dx_d[e];
        s1_dy_q[e]  <= dy_d[e];
        s2_p1_q[e]  <= s1_a_q[e] * s1_dy_q[e];
        s2_p2_q[e]  <= s1_dx_q[e] * s1_b_q[e];
        s2_dir_q[e] <= !s1_dy_q[e][DW-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      parity_q    <= 1'b0;
      out_valid_q <= 1'b0;
      inside_q    <= 1'b0;
    end else if (adv) begin
      s1_v_q      <= pop_o;
      s2_v_q      <= s1_v_q;
      out_valid_q <= 1'b0;
      if (s2_v_q) begin
        if (s2_ctl_q.last) begin
          out_valid_q <= 1'b1;
          inside_q    <= par_nxt;
          parity_q    <= 1'b0;
        end else begin
          parity_q <= par_nxt;
        end
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;

endmodule

// ----- rtl/point_in_polygon_crossing_test.sv -----
// channel  direction  handshake                payload
// in       input      in_valid_i / in_stall_o   query_x_i, query_y_i, corner_x_i, corner_y_i,
//                                               final_corner_i
// out      output     out_valid_o / out_stall_i inside_res_o
//
// one vertex per cycle while the queue is not full; a vertex is rounded and classified in the cycle it is taken
// a result passes after its last vertex through the queue, the two registered
// cross-multiply stages and the output register behind the queue
// reset clears the stored vertices, the parity, the queue and the pipeline valids
// a stalled result holds the back end; the queue keeps taking vertices until full
module point_in_polygon_crossing_test #(
  parameter int unsigned INT_BITS  = 16,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [INT_BITS+FRAC_BITS-1:0]   query_x_i,
  input  logic signed [INT_BITS+FRAC_BITS-1:0]   query_y_i,
  input  logic signed [INT_BITS+FRAC_BITS-1:0]   corner_x_i,
  input  logic signed [INT_BITS+FRAC_BITS-1:0]   corner_y_i,
  input  logic                                   final_corner_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   inside_res_o
);
  import pipct_pkg::*;

  localparam int unsigned IN_W   = INT_BITS + FRAC_BITS;
  localparam int unsigned VW     = INT_BITS + 1;
  localparam int unsigned DATA_W = 2 * IN_W + 6 * VW;
  localparam int unsigned CTL_W  = $bits(item_ctl_t);
  localparam int unsigned Q_W    = CTL_W + DATA_W;

  q_stat_t           q_stat;
  logic              q_push, q_pop;
  item_ctl_t         f_ctl, b_ctl;
  logic [DATA_W-1:0] f_data, b_data;
  logic [Q_W-1:0]    q_rdata;

  pipct_front #(
    .INT_BITS  (INT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .query_x_i      (query_x_i),
    .query_y_i      (query_y_i),
    .corner_x_i     (corner_x_i),
    .corner_y_i     (corner_y_i),
    .final_corner_i (final_corner_i),
    .q_stat_i       (q_stat),
    .push_o         (q_push),
    .ctl_o          (f_ctl),
    .data_o         (f_data)
  );

  pipct_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .pop_i   (q_pop),
    .wdata_i ({f_ctl, f_data}),
    .rdata_o (q_rdata),
    .stat_o  (q_stat)
  );

  assign b_ctl  = item_ctl_t'(q_rdata[Q_W-1 -: CTL_W]);
  assign b_data = q_rdata[DATA_W-1:0];

  pipct_back #(
    .INT_BITS  (INT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_stat_i     (q_stat),
    .pop_o        (q_pop),
    .ctl_i        (b_ctl),
    .data_i       (b_data),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .inside_res_o (inside_res_o)
  );

  // the front must never write into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full)
    else $error("vertex written into full queue");

  // the back end must never take from an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("vertex read from empty queue");

  // a queue that is not full and takes a push but no pop is not empty at the next edge
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push && !q_pop && !q_stat.full |=> !q_stat.empty)
    else $error("queue empty after a push");

endmodule

// ----- bench/pip_crossing_checker.sv -----
module pip_crossing_checker #(
  parameter int unsigned INT_BITS  = 16,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  logic signed [INT_BITS+FRAC_BITS-1:0] query_x_i,
  input  logic signed [INT_BITS+FRAC_BITS-1:0] query_y_i,
  input  logic signed [INT_BITS+FRAC_BITS-1:0] corner_x_i,
  input  logic signed [INT_BITS+FRAC_BITS-1:0] corner_y_i,
  input  logic                                 final_corner_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic                                 inside_res_i,
  input  logic                                 end_of_run_i,
  output int unsigned                          errors_o,
  output int unsigned                          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned W   = INT_BITS + FRAC_BITS;
  localparam longint      ONE = longint'(1) << FRAC_BITS;

  // polygon walk state, vertices held as rounded integers
  longint first_vx, first_vy, prev_vx, prev_vy;
  bit     odd_cross;
  bit     seen_first;
  bit     run_closed;
  bit     inside_want;

  // parity of every closed polygon, oldest first
  bit pending_inside[$];

  function automatic longint nearest_even(logic signed [W-1:0] v);
    longint s, q, frac;
    s = longint'(v);
    if (FRAC_BITS == 0) return s;
    q    = s >>> FRAC_BITS;
    frac = s - q * ONE;
    if (frac > ONE / 2 || (frac == ONE / 2 && q[0])) q++;
    return q;
  endfunction

  // edge (xi,yi)-(xj,yj) straddles the point's y and the point is left of the crossing
  function automatic bit crosses_left(longint xi, longint yi, longint xj, longint yj,
                                      longint px, longint py);
    longint dy, dx, lhs, rhs;
    if ((yi * ONE > py) == (yj * ONE > py)) return 1'b0;
    dy  = yj - yi;
    dx  = xj - xi;
    lhs = px - xi * ONE;
    rhs = py - yi * ONE;
    // same as px < xi + dx * rhs / dy, with the sign of dy folded in
    if (dy > 0) return lhs * dy < dx * rhs;
    return dx * rhs < lhs * dy;
  endfunction

  task automatic take_corner();
    longint px, py, cx, cy;
    px = longint'(query_x_i);
    py = longint'(query_y_i);
    cx = nearest_even(corner_x_i);
    cy = nearest_even(corner_y_i);
    if (!seen_first) begin
      first_vx   = cx;
      first_vy   = cy;
      seen_first = 1'b1;
    end else if (crosses_left(cx, cy, prev_vx, prev_vy, px, py)) begin
      odd_cross ^= 1'b1;
    end
    prev_vx = cx;
    prev_vy = cy;
    if (final_corner_i) begin
      if (crosses_left(first_vx, first_vy, prev_vx, prev_vy, px, py)) odd_cross ^= 1'b1;
      pending_inside.push_back(odd_cross);
      clear_walk();
    end
  endtask

  task automatic clear_walk();
    first_vx   = 0;
    first_vy   = 0;
    prev_vx    = 0;
    prev_vy    = 0;
    odd_cross  = 1'b0;
    seen_first = 1'b0;
  endtask

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_walk();
      pending_inside.delete();
      pending_o  = 0;
      errors_o   = 0;
      run_closed = 1'b0;
    end else begin
      if (in_valid_i && !in_stall_i) take_corner();
      if (out_valid_i && !out_stall_i) begin
        if (pending_inside.size() == 0) begin
          report_mismatch($sformatf("result inside=%b with no polygon closed", inside_res_i));
        end else begin
          inside_want = pending_inside.pop_front();
          if (inside_res_i !== inside_want)
            report_mismatch($sformatf("inside=%b, predicted %b", inside_res_i, inside_want));
        end
      end
      if (end_of_run_i && !run_closed) begin
        run_closed = 1'b1;
        if (pending_inside.size() != 0)
          report_mismatch($sformatf("%0d results never came out", pending_inside.size()));
      end
      pending_o = pending_inside.size();
    end
  end

endmodule

// ----- bench/tb_point_in_polygon_crossing_test.sv -----
module tb_point_in_polygon_crossing_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned INT_BITS  = 16;
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned W         = INT_BITS + FRAC_BITS;
  localparam int          ONE       = 1 << FRAC_BITS;
  localparam int unsigned CORNERS   = 1050;
  localparam int unsigned IDLE_MAX  = 2000;

  localparam logic signed [W-1:0] C_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] C_MIN = {1'b1, {(W-1){1'b0}}};

  typedef enum int {SPAN_SMALL, SPAN_TIES, SPAN_FULL, SPAN_EDGES} span_e;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic signed [W-1:0] query_x_i      = '0;
  logic signed [W-1:0] query_y_i      = '0;
  logic signed [W-1:0] corner_x_i     = '0;
  logic signed [W-1:0] corner_y_i     = '0;
  logic                final_corner_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic                inside_res_o;
  logic                end_of_run     = 1'b0;
  int unsigned         errors;
  int unsigned         pending;

  bit          calm = 1'b0;
  int unsigned stall_hold = 0;
  int unsigned stall_pick;
  int unsigned corners_sent = 0;
  int unsigned idle_cycles;

  always #10 clk_i = ~clk_i;

  point_in_polygon_crossing_test #(
    .INT_BITS (INT_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .query_x_i     (query_x_i),
    .query_y_i     (query_y_i),
    .corner_x_i    (corner_x_i),
    .corner_y_i    (corner_y_i),
    .final_corner_i(final_corner_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .inside_res_o  (inside_res_o)
  );

  pip_crossing_checker #(
    .INT_BITS (INT_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .query_x_i     (query_x_i),
    .query_y_i     (query_y_i),
    .corner_x_i    (corner_x_i),
    .corner_y_i    (corner_y_i),
    .final_corner_i(final_corner_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .inside_res_i  (inside_res_o),
    .end_of_run_i  (end_of_run),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  // receiver back-pressure: mostly short bursts, now and then a long one
  always @(negedge clk_i) begin
    if (calm) begin
      out_stall_i <= 1'b0;
      stall_hold = 0;
    end else if (stall_hold != 0) begin
      stall_hold--;
    end else begin
      stall_pick = $urandom_range(0, 9);
      if (stall_pick < 6) begin
        out_stall_i <= 1'b0;
        stall_hold = $urandom_range(0, 12);
      end else if (stall_pick < 9) begin
        out_stall_i <= 1'b1;
        stall_hold = $urandom_range(0, 3);
      end else begin
        out_stall_i <= 1'b1;
        stall_hold = $urandom_range(10, 40);
      end
    end
  end

  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < IDLE_MAX) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[%0t] no transaction for %0d cycles", $time, IDLE_MAX);
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic signed [W-1:0] fx(int units);
    return W'(units * ONE);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic logic signed [W-1:0] pick_coord(span_e span);
    logic signed [W-1:0] v;
    case (span)
      SPAN_SMALL: v = W'(int'($urandom_range(0, 16 * ONE - 1)) - 8 * ONE);
      // whole and half units only, so rounding ties and grid-aligned y show up often
      SPAN_TIES:  v = W'((int'($urandom_range(0, 32)) - 16) * ONE +
                         ($urandom_range(0, 1) ? ONE / 2 : 0));
      SPAN_EDGES: begin
        case ($urandom_range(0, 4))
          0:       v = C_MAX;
          1:       v = C_MIN;
          2:       v = '0;
          3:       v = '1;
          default: v = W'($urandom());
        endcase
      end
      default:    v = W'($urandom());
    endcase
    return v;
  endfunction

  function automatic span_e pick_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return SPAN_SMALL;
    if (r < 60) return SPAN_TIES;
    if (r < 85) return SPAN_FULL;
    return SPAN_EDGES;
  endfunction

  // starts and ends at a falling edge; drain holds off until every result is out
  task automatic send_corner(logic signed [W-1:0] qx, logic signed [W-1:0] qy,
                             logic signed [W-1:0] cx, logic signed [W-1:0] cy,
                             logic last, bit drain);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0 || drain) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
      if (drain) begin
        @(negedge clk_i);
        while (pending != 0) @(negedge clk_i);
      end
    end
    query_x_i      <= qx;
    query_y_i      <= qy;
    corner_x_i     <= cx;
    corner_y_i     <= cy;
    final_corner_i <= last;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    corners_sent++;
    @(negedge clk_i);
  endtask

  task automatic directed_polygons();
    // triangle with the point inside, then outside
    send_corner(fx(2) + W'(ONE / 2), fx(2) + W'(ONE / 2), fx(0), fx(0), 1'b0, 1'b0);
    send_corner(fx(2) + W'(ONE / 2), fx(2) + W'(ONE / 2), fx(10), fx(0), 1'b0, 1'b0);
    send_corner(fx(2) + W'(ONE / 2), fx(2) + W'(ONE / 2), fx(0), fx(10), 1'b1, 1'b0);
    send_corner(fx(8), fx(8), fx(0), fx(0), 1'b0, 1'b0);
    send_corner(fx(8), fx(8), fx(10), fx(0), 1'b0, 1'b0);
    send_corner(fx(8), fx(8), fx(0), fx(10), 1'b1, 1'b0);
    // single vertex polygons at the extremes
    send_corner(C_MIN, C_MIN, C_MAX, C_MAX, 1'b1, 1'b0);
    send_corner(C_MAX, C_MAX, C_MIN, C_MIN, 1'b1, 1'b0);
    // square with horizontal edges, point on the bottom edge's line
    send_corner(fx(2), fx(0), fx(0), fx(0), 1'b0, 1'b0);
    send_corner(fx(2), fx(0), fx(4), fx(0), 1'b0, 1'b0);
    send_corner(fx(2), fx(0), fx(4), fx(4), 1'b0, 1'b0);
    send_corner(fx(2), fx(0), fx(0), fx(4), 1'b1, 1'b0);
    // half-unit vertices: ties round to even, both signs
    send_corner('0, fx(1), W'(3 * ONE / 2), W'(ONE / 2), 1'b0, 1'b0);
    send_corner('0, fx(1), -W'(3 * ONE / 2), W'(5 * ONE / 2), 1'b0, 1'b0);
    send_corner('0, fx(1), W'(ONE / 2), W'(11 * ONE / 2), 1'b1, 1'b0);
    // point moves from vertex to vertex
    send_corner(fx(1), fx(1), fx(-3), fx(-3), 1'b0, 1'b0);
    send_corner(fx(9), fx(0), fx(5), fx(-3), 1'b0, 1'b0);
    send_corner(fx(-1), fx(2), fx(0), fx(6), 1'b1, 1'b0);
    // full-range triangle around the origin
    send_corner('0, '0, C_MIN, C_MIN, 1'b0, 1'b0);
    send_corner('0, '0, C_MAX, C_MIN, 1'b0, 1'b0);
    send_corner('1, W'(1), '0, C_MAX, 1'b1, 1'b0);
  endtask

  initial begin : stimulus
    int unsigned         poly_idx;
    int unsigned         verts;
    int unsigned         r;
    span_e               span;
    bit                  roam;
    logic signed [W-1:0] qx, qy;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    directed_polygons();

    poly_idx = 0;
    while (corners_sent < CORNERS) begin
      calm <= (poly_idx % 50) >= 40;
      span = pick_span();
      r    = $urandom_range(0, 99);
      if (r < 8)       verts = $urandom_range(1, 2);
      else if (r < 90) verts = $urandom_range(3, 6);
      else             verts = $urandom_range(7, 12);
      roam = $urandom_range(0, 4) == 0;
      qx   = pick_coord(span);
      qy   = pick_coord(span);
      for (int unsigned v = 0; v < verts; v++) begin
        if (roam) begin
          qx = pick_coord(span);
          qy = pick_coord(span);
        end
        send_corner(qx, qy, pick_coord(span), pick_coord(span), v == verts - 1,
                    v == 0 && (poly_idx == 30 || poly_idx == 150));
      end
      poly_idx++;
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    end_of_run <= 1'b1;
    repeat (2) @(negedge clk_i);

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
